// File: sv/aesc_pkg.sv
// ----------------------------------------------------------------------------
// aesc_pkg
// shared types, s-box tables and field helpers for the aes ecb block
// ----------------------------------------------------------------------------
package aesc_pkg;

    localparam int KEY_WORDS   = 60;
    localparam int KIDX_W      = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KLEN = 3'd4;

    localparam logic REQ_ENC = 1'b0;

    typedef struct packed {
        logic         dec;
        logic [127:0] blk;
    } req_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte i of the state sits at bits 127-8i
    function automatic logic [7:0] sb(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[127-8*(r+4*c) -: 8] = sbox(sb(s, r + 4*((c + r) % 4)));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
            m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return last ? t : m;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] m;
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a[k]  = sb(s, 4*c+k);
                x2[k] = xt(a[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++)
            begin
                // coefficients e, b, d, 9 rotated by row
                m[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return m;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[127-8*(r + 4*((c + r) % 4)) -: 8] = inv_sbox(sb(s, r + 4*c));
            end
        end
        return t;
    endfunction

endpackage

// File: sv/aesc_front.sv
// ----------------------------------------------------------------------------
// aesc_front
// accepts requests and holds them in a short queue for the round engine
// ----------------------------------------------------------------------------
module aesc_front
    import aesc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  req_t         in_req,
    output logic         q_valid,
    input  logic         q_pop,
    output req_t         q_req
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t              mem_reg [DEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg;
    logic              push;

    assign in_ready = (cnt_reg != (PW+1)'(DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end
endmodule

// File: sv/aesc_back.sv
// ----------------------------------------------------------------------------
// aesc_back
// key expansion and iterative round engine with a single round unit
// ----------------------------------------------------------------------------
module aesc_back
    import aesc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [63:0]  cfg_data,
    input  logic         q_valid,
    output logic         q_pop,
    input  req_t         q_req,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] out_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXP  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_RND  = 2'd3;

    logic [63:0]       key_reg [4];
    logic [1:0]        klen_reg;
    logic              ready_reg, ready_next;
    logic [1:0]        st_reg, st_next;
    logic [KIDX_W-1:0] i_reg, i_next;
    logic [3:0]        nk_reg, nk_next;
    logic [KIDX_W-1:0] total_reg, total_next;
    logic [3:0]        nr_reg, nr_next;
    logic [7:0]        rcon_reg, rcon_next;
    logic [2:0]        ph_reg, ph_next;
    logic [3:0]        rnd_reg, rnd_next;
    logic [2:0]        cyc_reg, cyc_next;
    logic              dec_reg, dec_next;
    logic              ov_reg, ov_next;
    logic [31:0]       rk_mem [KEY_WORDS];
    logic [31:0]       hist_reg [8];
    logic [31:0]       rd_reg;
    logic [127:0]      rk_reg;
    logic [127:0]      s_reg;
    logic [127:0]      ob_reg;
    logic [3:0]        nk_c;
    logic [31:0]       key_w, t_w, new_w, exp_w;
    logic              exp_key;
    logic [KIDX_W-1:0] rd_addr;
    logic              round_done, first_rnd, last_rnd;
    logic [127:0]      key_full, pre, round_out;

    always_comb
    begin
        unique case (klen_reg)
            KLEN_128: nk_c = 4'd4;
            KLEN_192: nk_c = 4'd6;
            default:  nk_c = 4'd8;
        endcase
    end

    // expansion word: key words first, then the recurrence on the history
    always_comb
    begin
        key_w   = i_reg[0] ? key_reg[i_reg[2:1]][31:0] : key_reg[i_reg[2:1]][63:32];
        exp_key = (i_reg < {2'b00, nk_reg});
        t_w     = hist_reg[0];
        if (ph_reg == 3'd0)
        begin
            t_w = sub_word({hist_reg[0][23:0], hist_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (nk_reg == 4'd8 && ph_reg == 3'd4)
        begin
            t_w = sub_word(hist_reg[0]);
        end
        new_w = hist_reg[3'(nk_reg - 4'd1)] ^ t_w;
        exp_w = exp_key ? key_w : new_w;
    end

    // round key read: one word per cycle, data registered in the cycle after
    assign rd_addr = {rnd_reg, cyc_reg[1:0]};

    // history kept newest first
    always_ff @(posedge clk)
    begin
        if (st_reg == S_EXP)
        begin
            rk_mem[i_reg] <= exp_w;
            for (int k = 7; k > 0; k--)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
            hist_reg[0] <= exp_w;
        end
        rd_reg <= rk_mem[rd_addr];
    end

    assign key_full   = {rk_reg[95:0], rd_reg};
    assign round_done = (st_reg == S_RND) && (cyc_reg == 3'd4);
    assign first_rnd  = dec_reg ? (rnd_reg == nr_reg) : (rnd_reg == 4'd0);
    assign last_rnd   = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == nr_reg);

    always_comb
    begin
        pre = s_reg;
        if (!first_rnd)
        begin
            pre = dec_reg ? dec_round(s_reg) : enc_round(s_reg, last_rnd);
        end
        round_out = pre ^ key_full;
        if (dec_reg && !first_rnd && !last_rnd)
        begin
            round_out = inv_mix(round_out);
        end
    end

    always_comb
    begin
        st_next    = st_reg;
        i_next     = i_reg;
        nk_next    = nk_reg;
        total_next = total_reg;
        nr_next    = nr_reg;
        rcon_next  = rcon_reg;
        ph_next    = ph_reg;
        rnd_next   = rnd_reg;
        cyc_next   = cyc_reg;
        dec_next   = dec_reg;
        ready_next = ready_reg;
        ov_next    = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    if (ready_reg)
                    begin
                        st_next = S_LOAD;
                    end
                    else
                    begin
                        st_next    = S_EXP;
                        i_next     = '0;
                        nk_next    = nk_c;
                        total_next = {nk_c, 2'b00} + 6'd28;
                        nr_next    = nk_c + 4'd6;
                        rcon_next  = 8'h01;
                        ph_next    = '0;
                    end
                end
            end
            S_EXP:
            begin
                i_next = i_reg + 6'd1;
                if (!exp_key)
                begin
                    if (ph_reg == 3'd0)
                    begin
                        rcon_next = xt(rcon_reg);
                    end
                    ph_next = (ph_reg == 3'(nk_reg - 4'd1)) ? 3'd0 : ph_reg + 3'd1;
                end
                if (i_reg == total_reg - 6'd1)
                begin
                    st_next    = S_LOAD;
                    ready_next = 1'b1;
                end
            end
            S_LOAD:
            begin
                st_next  = S_RND;
                dec_next = (q_req.dec != REQ_ENC);
                rnd_next = (q_req.dec != REQ_ENC) ? nr_reg : 4'd0;
                cyc_next = '0;
            end
            S_RND:
            begin
                cyc_next = (cyc_reg == 3'd4) ? 3'd0 : cyc_reg + 3'd1;
                if (round_done)
                begin
                    if (last_rnd)
                    begin
                        st_next = S_IDLE;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        rnd_next = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    end
                end
            end
        endcase
        if (cfg_we && cfg_idx <= REG_KLEN)
        begin
            ready_next = 1'b0;
        end
    end

    assign q_pop     = (st_reg == S_LOAD);
    assign out_valid = ov_reg;
    assign out_data  = ob_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == S_LOAD)
        begin
            s_reg <= q_req.blk;
        end
        else if (round_done)
        begin
            s_reg <= round_out;
        end
        if (st_reg == S_RND && cyc_reg != 3'd0)
        begin
            rk_reg <= {rk_reg[95:0], rd_reg};
        end
        if (round_done && last_rnd)
        begin
            ob_reg <= round_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            klen_reg  <= KLEN_128;
            ready_reg <= 1'b0;
            st_reg    <= S_IDLE;
            i_reg     <= '0;
            nk_reg    <= 4'd4;
            total_reg <= 6'd44;
            nr_reg    <= 4'd10;
            rcon_reg  <= 8'h01;
            ph_reg    <= '0;
            rnd_reg   <= '0;
            cyc_reg   <= '0;
            dec_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            i_reg     <= i_next;
            nk_reg    <= nk_next;
            total_reg <= total_next;
            nr_reg    <= nr_next;
            rcon_reg  <= rcon_next;
            ph_reg    <= ph_next;
            rnd_reg   <= rnd_next;
            cyc_reg   <= cyc_next;
            dec_reg   <= dec_next;
            ready_reg <= ready_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_KEY0: key_reg[0] <= cfg_data;
                    REG_KEY1: key_reg[1] <= cfg_data;
                    REG_KEY2: key_reg[2] <= cfg_data;
                    REG_KEY3: key_reg[3] <= cfg_data;
                    REG_KLEN: klen_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: sv/aes_block_cipher_ecb.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb
// aes-128/192/256 ecb cipher and inverse cipher, one block per request
//
// channel   dir  tdata bits                            tuser
// s_axis    in   [63:0] data_hi, [127:64] data_lo      [0] req_type
// m_axis    out  [63:0] result_hi, [127:64] result_lo  -
// cfg       in   cfg_index selects key_word_0..3, key_length
//
// a block runs its nr+1 rounds one after another on the single round unit,
// with the round key read one word at a time. after a key write the next
// block first expands the schedule, one word per cycle. reset clears all
// control state.
// a two-entry request queue keeps accepting while the engine is busy; a
// finished result waits in the output register and holds off the next block.
// ----------------------------------------------------------------------------
module aes_block_cipher_ecb
    import aesc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // data_hi, data_lo
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_hi, result_lo
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    req_t   in_req, q_req;
    logic   q_valid, q_pop;
    logic [127:0] res;

    assign in_req       = '{dec: s_axis_tuser, blk: {s_axis_tdata[63:0], s_axis_tdata[127:64]}};
    assign m_axis_tdata = {res[63:0], res[127:64]};

    aesc_front #(.DEPTH(QDEPTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    aesc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );
endmodule

// File: sv/aesc_checker.sv
// ----------------------------------------------------------------------------
// aesc_checker
// port level checks for the aes ecb block
// ----------------------------------------------------------------------------
module aesc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_no_result_after_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid || $past(rst_n))
        else $error("result shown out of reset");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("back to back results without a request");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
        else $error("handshake signal unknown");
endmodule

bind aes_block_cipher_ecb aesc_checker u_aesc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb_aes_block_cipher_ecb.sv
// ----------------------------------------------------------------------------
// tb_aes_block_cipher_ecb
// self-checking bench for the aes ecb block: directed known-answer requests for
// every key size and both directions, then random blocks under several key
// settings and handshake idling; results checked by known answer or predictor
// ----------------------------------------------------------------------------
module tb_aes_block_cipher_ecb;
    import aesc_pkg::*;

    localparam logic [1:0]   KLEN_256 = 2'd2;
    localparam logic [1:0]   KLEN_ALT = 2'd3;
    localparam logic         REQ_DEC  = 1'b1;
    localparam logic [2:0]   REG_NONE = 3'd7;
    localparam logic [63:0]  FK0      = 64'h0001020304050607;
    localparam logic [63:0]  FK1      = 64'h08090a0b0c0d0e0f;
    localparam logic [63:0]  FK2      = 64'h1011121314151617;
    localparam logic [63:0]  FK3      = 64'h18191a1b1c1d1e1f;
    localparam logic [63:0]  ZK       = 64'h0;
    localparam logic [63:0]  OK       = '1;
    localparam logic [127:0] FPT      = 128'h00112233445566778899aabbccddeeff;
    localparam logic [127:0] ONES     = '1;

    typedef struct {
        logic         load;
        logic [63:0]  k0;
        logic [63:0]  k1;
        logic [63:0]  k2;
        logic [63:0]  k3;
        logic [1:0]   klen;
        logic         op;
        logic [127:0] blk;
        logic         known;
        logic [127:0] want;
    } vec_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    logic [63:0]  key_regs [4];
    logic [1:0]   klen_model;
    logic [31:0]  sched [60];
    int           n_rounds;
    bit           sched_valid;

    logic [127:0] pending_blocks [$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;

    aes_block_cipher_ecb DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic void build_schedule();
        logic [7:0]  rcon [11];
        logic [31:0] t;
        int nk;
        int total;
        rcon = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
        nk = (klen_model == KLEN_128) ? 4 : (klen_model == KLEN_192) ? 6 : 8;
        n_rounds = nk + 6;
        total = 4 * (n_rounds + 1);
        for (int i = 0; i < nk; i++)
            sched[i] = (i % 2) ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
        for (int i = nk; i < total; i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
                t = sub_word({t[23:0], t[31:24]}) ^ {rcon[i / nk], 24'h0};
            else if (nk > 6 && i % nk == 4)
                t = sub_word(t);
            sched[i] = sched[i - nk] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    // state as 16 bytes, byte 0 first
    function automatic logic [127:0] cipher_block(input logic op, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] fm [4];
        logic [7:0] im [4];
        logic [127:0] res;
        int rd;
        int step;
        fm = '{8'h02, 8'h03, 8'h01, 8'h01};
        im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        if (!sched_valid) build_schedule();
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
        rd = (op == REQ_ENC) ? 0 : n_rounds;
        step = (op == REQ_ENC) ? 1 : -1;
        for (int k = 0; k <= n_rounds; k++)
        begin
            if (k > 0)
            begin
                t = s;
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (op == REQ_ENC)
                            s[r + 4 * c] = sbox(t[r + 4 * ((c + r) % 4)]);
                        else
                            s[r + 4 * ((c + r) % 4)] = inv_sbox(t[r + 4 * c]);
            end
            if (op != REQ_ENC || k == 0 || k == n_rounds)
            begin
                for (int c = 0; c < 4; c++)
                    for (int b = 0; b < 4; b++)
                        s[4 * c + b] ^= sched[rd * 4 + c][31 - 8 * b -: 8];
            end
            if (k > 0 && k < n_rounds)
            begin
                if (op == REQ_ENC)
                begin
                    // mix then key for this round
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                        begin
                            s[4 * c + r] = 8'h00;
                            for (int j = 0; j < 4; j++)
                                s[4 * c + r] ^= gmul(t[4 * c + j], fm[(j + 4 - r) % 4]);
                        end
                    for (int c = 0; c < 4; c++)
                        for (int b = 0; b < 4; b++)
                            s[4 * c + b] ^= sched[rd * 4 + c][31 - 8 * b -: 8];
                end
                else
                begin
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                        begin
                            s[4 * c + r] = 8'h00;
                            for (int j = 0; j < 4; j++)
                                s[4 * c + r] ^= gmul(t[4 * c + j], im[(j + 4 - r) % 4]);
                        end
                end
            end
            rd += step;
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KEY0: key_regs[0] = val;
            REG_KEY1: key_regs[1] = val;
            REG_KEY2: key_regs[2] = val;
            REG_KEY3: key_regs[3] = val;
            REG_KLEN: klen_model = (val[1:0] == KLEN_ALT) ? KLEN_256 : val[1:0];
            default: ;
        endcase
        if (idx <= REG_KLEN) sched_valid = 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [1:0] klen);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KLEN, {62'h0, klen});
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_request(input logic op, input logic [127:0] blk,
                                input logic known, input logic [127:0] want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_blocks.push_back(known ? want : cipher_block(op, blk));
    endtask

    task automatic send_random(input int count);
        logic [127:0] blk;
        for (int i = 0; i < count; i++)
        begin
            blk = {$urandom, $urandom, $urandom, $urandom};
            send_request(logic'($urandom_range(1)), blk, 1'b0, '0);
        end
    endtask

    // receive side: idle, check against the oldest expected block
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_blocks.size() == 0)
                begin
                    $error("unexpected request result %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (m_axis_tdata[63:0] !== want[127:64])
                    begin
                        $error("result_hi expected %h actual %h", want[127:64],
                               m_axis_tdata[63:0]);
                        errors++;
                    end
                    if (m_axis_tdata[127:64] !== want[63:0])
                    begin
                        $error("result_lo expected %h actual %h", want[63:0],
                               m_axis_tdata[127:64]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        vec_t vecs [$];
        vec_t v;
        logic [63:0] k0, k1, k2, k3;
        errors        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        klen_model    = KLEN_128;
        sched_valid   = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ENC;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_KEY0;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key straight after reset
        vecs.push_back('{1'b0, ZK, ZK, ZK, ZK, KLEN_128, REQ_ENC, 128'h0,
                         1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e});
        vecs.push_back('{1'b0, ZK, ZK, ZK, ZK, KLEN_128, REQ_DEC,
                         128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, 128'h0});
        vecs.push_back('{1'b0, ZK, ZK, ZK, ZK, KLEN_128, REQ_ENC, ONES, 1'b0, 128'h0});
        vecs.push_back('{1'b0, ZK, ZK, ZK, ZK, KLEN_128, REQ_DEC, ONES, 1'b0, 128'h0});
        // standard key-size vectors, both directions
        vecs.push_back('{1'b1, FK0, FK1, ZK, ZK, KLEN_128, REQ_ENC, FPT,
                         1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a});
        vecs.push_back('{1'b0, FK0, FK1, ZK, ZK, KLEN_128, REQ_DEC,
                         128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, FPT});
        vecs.push_back('{1'b0, FK0, FK1, ZK, ZK, KLEN_128, REQ_ENC, 128'h0, 1'b0, 128'h0});
        vecs.push_back('{1'b1, FK0, FK1, FK2, ZK, KLEN_192, REQ_ENC, FPT,
                         1'b1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191});
        vecs.push_back('{1'b0, FK0, FK1, FK2, ZK, KLEN_192, REQ_DEC,
                         128'hdda97ca4864cdfe06eaf70a0ec0d7191, 1'b1, FPT});
        vecs.push_back('{1'b1, FK0, FK1, FK2, FK3, KLEN_256, REQ_ENC, FPT,
                         1'b1, 128'h8ea2b7ca516745bfeafc49904b496089});
        vecs.push_back('{1'b0, FK0, FK1, FK2, FK3, KLEN_256, REQ_DEC,
                         128'h8ea2b7ca516745bfeafc49904b496089, 1'b1, FPT});
        // length code 3 behaves as 256, all-ones key
        vecs.push_back('{1'b1, OK, OK, OK, OK, KLEN_ALT, REQ_ENC, ONES, 1'b0, 128'h0});
        vecs.push_back('{1'b0, OK, OK, OK, OK, KLEN_ALT, REQ_DEC, 128'h0, 1'b0, 128'h0});
        foreach (vecs[i])
        begin
            v = vecs[i];
            if (v.load)
            begin
                drain();
                load_key(v.k0, v.k1, v.k2, v.k3, v.klen);
            end
            send_request(v.op, v.blk, v.known, v.want);
        end
        drain();

        // rewrite with same value forces re-expansion; out-of-range index ignored
        write_reg(REG_KEY2, key_regs[2]);
        write_reg(REG_NONE, '1);
        send_request(REQ_ENC, 128'h8000000000000000_0000000000000001, 1'b0, '0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            k0 = {$urandom, $urandom};
            k1 = {$urandom, $urandom};
            k2 = {$urandom, $urandom};
            k3 = {$urandom, $urandom};
            load_key(k0, k1, k2, k3, 2'(phase % 4));
            send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 60 : 0;
            recv_idle_pct = (phase < 2) ? 60 : (phase < 4) ? 20 : 0;
            send_random(90);
            // hold off until everything in flight has come back
            s_axis_tvalid <= 1'b0;
            while (pending_blocks.size() != 0) @(posedge clk);
            send_random(90);
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
